// File: hw/rtl/cps_pkg.sv
// Shared types and character codes for the comment and preprocessor stripper.
// No dependencies; imported by cps_step and c_comment_preproc_stripper.
package cps_pkg;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_NL    = 8'h0a;

  localparam logic [1:0] MODE_TEXT  = 2'd0;
  localparam logic [1:0] MODE_LINE  = 2'd1;
  localparam logic [1:0] MODE_BLOCK = 2'd2;
  localparam logic [1:0] MODE_DIR   = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic       line_start;
    logic       pend;
  } scan_st_t;

  localparam scan_st_t SCAN_RESET = '{mode: MODE_TEXT, line_start: 1'b1, pend: 1'b0};

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       end_of_text;
  } res_t;

endpackage

// File: hw/rtl/c_comment_preproc_stripper.sv
// Top level of the C comment and preprocessor-line stripper: scan state,
// two-word result queue and handshakes. Depends on cps_pkg and cps_step.
//
// A byte is taken in every cycle in which the result queue is empty or its
// last word leaves in that cycle, so plain text streams at one byte per cycle
// unless the output stalls. A byte that yields two words (a held '/' followed
// by a kept byte) fills both queue entries, and the input holds until the
// second word leaves. Bytes that yield no word (comment and directive bodies)
// are still accepted and leave the queue empty. The final byte of a text
// always yields at least one word, the last of which carries end_of_text.
module c_comment_preproc_stripper (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_is_final,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_end_of_text
);
  import cps_pkg::*;

  scan_st_t   st_r, st_nxt, step_st;
  res_t       q0_r, q1_r, q0_nxt, q1_nxt;
  res_t       res0, res1;
  logic [1:0] cnt_r, cnt_nxt, res_cnt;
  logic       pop, accept;

  cps_step u_step (
    .in_byte     (in_byte),
    .in_is_final (in_is_final),
    .st          (st_r),
    .st_nxt      (step_st),
    .res0        (res0),
    .res1        (res1),
    .res_cnt     (res_cnt)
  );

  assign pop      = out_valid && !out_stall;
  assign in_stall = !((cnt_r == 2'd0) || (cnt_r == 2'd1 && pop));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    st_nxt  = st_r;
    q0_nxt  = q0_r;
    q1_nxt  = q1_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      st_nxt  = step_st;
      q0_nxt  = res0;
      q1_nxt  = res1;
      cnt_nxt = res_cnt;
    end else if (pop) begin
      q0_nxt  = q1_r;
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= SCAN_RESET;
      cnt_r <= 2'd0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  assign out_valid       = (cnt_r != 2'd0);
  assign out_byte        = q0_r.data;
  assign out_byte_valid  = q0_r.byte_valid;
  assign out_end_of_text = q0_r.end_of_text;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result queue count out of range");

  a_final_reset: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_is_final |=> st_r == SCAN_RESET)
    else $error("scan state not reset after final byte");

  a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_end_of_text && out_byte == 8'h00)
    else $error("bare word is not a clean end marker");

  a_final_word: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_is_final |=> out_valid)
    else $error("final byte produced no word");

  a_two_words: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && cnt_r == 2'd2 |-> !out_end_of_text)
    else $error("end marker ahead of a queued word");

endmodule

// File: hw/rtl/cps_step.sv
// Combinational scan step: one source byte and the scan state in, up to two
// result words and the next scan state out. Depends on cps_pkg.
module cps_step (
  input  logic [7:0]       in_byte,
  input  logic             in_is_final,
  input  cps_pkg::scan_st_t st,
  output cps_pkg::scan_st_t st_nxt,
  output cps_pkg::res_t    res0,
  output cps_pkg::res_t    res1,
  output logic [1:0]       res_cnt
);
  import cps_pkg::*;

  scan_st_t s;
  logic     do_scan;
  logic     slash_emit;
  logic     byte_emit;
  logic     flush_emit;
  logic [1:0] n;

  always_comb begin
    s          = st;
    do_scan    = 1'b0;
    slash_emit = 1'b0;
    byte_emit  = 1'b0;
    flush_emit = 1'b0;

    if (st.pend) begin
      s.pend = 1'b0;
      case (st.mode)
        MODE_TEXT: begin
          if (in_byte == CH_SLASH) begin
            s.mode = MODE_LINE;
          end else if (in_byte == CH_STAR) begin
            s.mode = MODE_BLOCK;
          end else begin
            slash_emit = 1'b1;
            do_scan    = 1'b1;
          end
        end
        MODE_BLOCK: begin
          if (in_byte == CH_SLASH) begin
            s.mode = MODE_TEXT;
          end else begin
            do_scan = 1'b1;
          end
        end
        MODE_DIR: begin
          do_scan = (in_byte != CH_NL);
        end
        default: begin
          do_scan = 1'b1;
        end
      endcase
    end else begin
      do_scan = 1'b1;
    end

    if (do_scan) begin
      case (s.mode)
        MODE_LINE: begin
          if (in_byte == CH_NL) begin
            s.mode       = MODE_TEXT;
            s.line_start = 1'b1;
            byte_emit    = 1'b1;
          end
        end
        MODE_BLOCK: begin
          if (in_byte == CH_STAR) begin
            s.pend = 1'b1;
          end else if (in_byte == CH_NL) begin
            byte_emit = 1'b1;
          end
        end
        MODE_DIR: begin
          if (in_byte == CH_BSL) begin
            s.pend = 1'b1;
          end else if (in_byte == CH_NL) begin
            s.mode       = MODE_TEXT;
            s.line_start = 1'b1;
            byte_emit    = 1'b1;
          end
        end
        default: begin
          if (s.line_start && in_byte == CH_HASH) begin
            s.mode = MODE_DIR;
          end else begin
            s.line_start = (in_byte == CH_NL);
            if (in_byte == CH_SLASH) begin
              s.pend = 1'b1;
            end else begin
              byte_emit = 1'b1;
            end
          end
        end
      endcase
    end

    flush_emit = in_is_final && s.pend && (s.mode == MODE_TEXT);

    n = {1'b0, slash_emit} + {1'b0, byte_emit} + {1'b0, flush_emit};

    res0.data        = slash_emit ? CH_SLASH : (byte_emit ? in_byte : CH_SLASH);
    res0.byte_valid  = 1'b1;
    res0.end_of_text = in_is_final && (n == 2'd1);
    res1.data        = in_byte;
    res1.byte_valid  = 1'b1;
    res1.end_of_text = in_is_final;

    if (in_is_final && n == 2'd0) begin
      res0.data        = 8'h00;
      res0.byte_valid  = 1'b0;
      res0.end_of_text = 1'b1;
      n                = 2'd1;
    end

    res_cnt = n;
    st_nxt  = in_is_final ? SCAN_RESET : s;
  end

endmodule

// File: dv/testbench.sv
// Self-checking testbench for c_comment_preproc_stripper: directed rows, then random C-like text.
// Random idling on both handshakes; expected words come from a local scan model or, for fixed rows, the table.
// Depends on cps_pkg and the RTL of the block.
module testbench;
  import cps_pkg::*;

  localparam int DIR_N     = 28;
  localparam int RAND_N    = 1750;
  localparam int IDLE_MAX  = 1000;
  localparam int DRAIN_CYC = 20;

  localparam res_t NO_W     = '0;
  localparam res_t END_MARK = '{data: 8'h00, byte_valid: 1'b0, end_of_text: 1'b1};

  typedef struct packed {
    logic [7:0] b;
    logic       fin;
    logic       typed;
    logic [1:0] n;
    res_t       w0;
    res_t       w1;
  } dir_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_is_final;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_end_of_text;

  dir_row_t   cur_row;
  dir_row_t   dir_tab [DIR_N];
  scan_st_t   scan;
  res_t       strip_w [0:1];
  int         strip_n;
  res_t       kept_q [$];
  logic [7:0] src_q [$];
  int         n_err;
  int         idle_cyc;
  logic       calm_in;
  logic       calm_out;

  c_comment_preproc_stripper i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_is_final     (in_is_final),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_end_of_text (out_end_of_text)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic res_t word_of(logic [7:0] c, logic eot);
    return '{data: c, byte_valid: 1'b1, end_of_text: eot};
  endfunction

  function automatic dir_row_t pred_row(logic [7:0] b, logic fin);
    return '{b: b, fin: fin, typed: 1'b0, n: 2'd0, w0: NO_W, w1: NO_W};
  endfunction

  function automatic dir_row_t fixed_row(logic [7:0] b, logic fin, logic [1:0] n,
                                         res_t w0, res_t w1);
    return '{b: b, fin: fin, typed: 1'b1, n: n, w0: w0, w1: w1};
  endfunction

  function automatic void keep_char(logic [7:0] c);
    strip_w[strip_n] = word_of(c, 1'b0);
    strip_n++;
  endfunction

  function automatic void scan_char(logic [7:0] b);
    case (scan.mode)
      MODE_LINE: begin
        if (b == CH_NL) begin
          scan.mode = MODE_TEXT;
          scan.line_start = 1'b1;
          keep_char(b);
        end
      end
      MODE_BLOCK: begin
        if (b == CH_STAR) scan.pend = 1'b1;
        else if (b == CH_NL) keep_char(b);
      end
      MODE_DIR: begin
        if (b == CH_BSL) begin
          scan.pend = 1'b1;
        end else if (b == CH_NL) begin
          scan.mode = MODE_TEXT;
          scan.line_start = 1'b1;
          keep_char(b);
        end
      end
      default: begin
        if (scan.line_start && b == CH_HASH) begin
          scan.mode = MODE_DIR;
        end else begin
          scan.line_start = (b == CH_NL);
          if (b == CH_SLASH) scan.pend = 1'b1;
          else keep_char(b);
        end
      end
    endcase
  endfunction

  function automatic void strip_byte(logic [7:0] b, logic fin);
    strip_n = 0;
    if (scan.pend) begin
      scan.pend = 1'b0;
      case (scan.mode)
        MODE_TEXT: begin
          if (b == CH_SLASH) begin
            scan.mode = MODE_LINE;
          end else if (b == CH_STAR) begin
            scan.mode = MODE_BLOCK;
          end else begin
            keep_char(CH_SLASH);
            scan_char(b);
          end
        end
        MODE_BLOCK: begin
          if (b == CH_SLASH) scan.mode = MODE_TEXT;
          else scan_char(b);
        end
        MODE_DIR: begin
          if (b != CH_NL) scan_char(b);
        end
        default: scan_char(b);
      endcase
    end else begin
      scan_char(b);
    end
    if (fin) begin
      if (scan.pend && scan.mode == MODE_TEXT) keep_char(CH_SLASH);
      if (strip_n == 0) begin
        strip_w[0] = END_MARK;
        strip_n = 1;
      end else begin
        strip_w[strip_n-1].end_of_text = 1'b1;
      end
      scan = SCAN_RESET;
    end
  endfunction

  function automatic logic [7:0] pick_letter();
    logic [7:0] c;
    c = 8'($urandom_range(97, 122));
    return c;
  endfunction

  function automatic void src_add(logic [7:0] c);
    src_q.insert(src_q.size(), c);
  endfunction

  function automatic void want_add(res_t w);
    kept_q.insert(kept_q.size(), w);
  endfunction

  task automatic add_piece();
    int         kind;
    int         len;
    int         sel;
    logic [7:0] c;
    kind = $urandom_range(0, 9);
    len  = $urandom_range(0, 6);
    case (kind)
      0, 1: begin
        for (int i = 0; i <= len; i++) src_add(pick_letter());
        if ($urandom_range(0, 1)) src_add(8'h20);
      end
      2: src_add(CH_NL);
      3: begin
        src_add(CH_SLASH);
        src_add(CH_SLASH);
        for (int i = 0; i < len; i++)
          src_add($urandom_range(0, 3) == 0 ? CH_STAR : pick_letter());
        src_add(CH_NL);
      end
      4: begin
        src_add(CH_SLASH);
        src_add(CH_STAR);
        for (int i = 0; i < len; i++) begin
          sel = $urandom_range(0, 5);
          c = (sel == 0) ? CH_STAR : (sel == 1) ? CH_NL : (sel == 2) ? CH_SLASH : pick_letter();
          src_add(c);
        end
        src_add(CH_STAR);
        src_add(CH_SLASH);
      end
      5: begin
        src_add(CH_NL);
        src_add(CH_HASH);
        for (int i = 0; i < len; i++) src_add(pick_letter());
        if ($urandom_range(0, 1)) begin
          src_add(CH_BSL);
          if ($urandom_range(0, 3) != 0) src_add(CH_NL);
          src_add(pick_letter());
        end
        src_add(CH_NL);
      end
      6: begin
        sel = $urandom_range(0, 3);
        c = (sel == 0) ? CH_SLASH : (sel == 1) ? CH_STAR : (sel == 2) ? CH_HASH : CH_BSL;
        src_add(c);
      end
      7: src_add(8'($urandom_range(0, 255)));
      8: for (int i = 0; i < len; i++) src_add(8'($urandom_range(0, 255)));
      default: begin
        src_add(CH_SLASH);
        src_add($urandom_range(0, 1) ? pick_letter() : 8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  task automatic send_word(dir_row_t r);
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_byte     <= r.b;
    in_is_final <= r.fin;
    cur_row     <= r;
    do @(posedge clk); while (in_stall);
  endtask

  always @(posedge clk) begin : check_words
    res_t want;
    logic moved;
    moved = 1'b0;
    if (rst_n && in_valid && !in_stall) begin
      moved = 1'b1;
      strip_byte(in_byte, in_is_final);
      if (cur_row.typed) begin
        if (cur_row.n > 0) want_add(cur_row.w0);
        if (cur_row.n > 1) want_add(cur_row.w1);
      end else begin
        for (int i = 0; i < strip_n; i++) want_add(strip_w[i]);
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      moved = 1'b1;
      if (kept_q.size() == 0) begin
        $error("unexpected word: out_byte %02h byte_valid %b end_of_text %b",
               out_byte, out_byte_valid, out_end_of_text);
        n_err++;
      end else begin
        want = kept_q.pop_front();
        if (out_byte !== want.data) begin
          $error("out_byte: expected %02h, got %02h", want.data, out_byte);
          n_err++;
        end
        if (out_byte_valid !== want.byte_valid) begin
          $error("out_byte_valid: expected %b, got %b", want.byte_valid, out_byte_valid);
          n_err++;
        end
        if (out_end_of_text !== want.end_of_text) begin
          $error("out_end_of_text: expected %b, got %b", want.end_of_text, out_end_of_text);
          n_err++;
        end
      end
    end
    idle_cyc = moved ? 0 : idle_cyc + 1;
    if (idle_cyc >= IDLE_MAX) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin : drive_out
    int hold;
    int n_out;
    n_out    = 0;
    calm_out = 1'b0;
    forever begin
      hold = calm_out ? 0 : $urandom_range(0, 9);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid));
      n_out++;
      if (n_out % 64 == 0) calm_out = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin : drive_in
    dir_row_t r;
    int       n_sent;
    n_err       = 0;
    idle_cyc    = 0;
    calm_in     = 1'b0;
    scan        = SCAN_RESET;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_byte     <= 8'h00;
    in_is_final <= 1'b0;
    cur_row     <= '0;
    dir_tab = '{
      fixed_row(8'h00, 1'b0, 2'd1, word_of(8'h00, 1'b0), NO_W),
      fixed_row(8'hff, 1'b0, 2'd1, word_of(8'hff, 1'b0), NO_W),
      fixed_row(CH_NL, 1'b0, 2'd1, word_of(CH_NL, 1'b0), NO_W),
      fixed_row(CH_HASH, 1'b0, 2'd0, NO_W, NO_W),
      pred_row(8'h64, 1'b0),
      pred_row(CH_BSL, 1'b0),
      pred_row(CH_NL, 1'b0),
      pred_row(CH_BSL, 1'b0),
      pred_row(8'h65, 1'b0),
      pred_row(CH_NL, 1'b0),
      pred_row(CH_SLASH, 1'b0),
      pred_row(8'h71, 1'b0),
      pred_row(CH_SLASH, 1'b0),
      pred_row(CH_SLASH, 1'b0),
      pred_row(CH_STAR, 1'b0),
      pred_row(CH_NL, 1'b0),
      pred_row(CH_SLASH, 1'b0),
      pred_row(CH_STAR, 1'b0),
      pred_row(CH_NL, 1'b0),
      pred_row(CH_STAR, 1'b0),
      pred_row(CH_STAR, 1'b0),
      pred_row(CH_SLASH, 1'b0),
      pred_row(CH_SLASH, 1'b0),
      pred_row(CH_HASH, 1'b0),
      fixed_row(CH_SLASH, 1'b1, 2'd1, word_of(CH_SLASH, 1'b1), NO_W),
      fixed_row(CH_HASH, 1'b1, 2'd1, END_MARK, NO_W),
      pred_row(CH_SLASH, 1'b0),
      pred_row(CH_STAR, 1'b1)
    };
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < DIR_N; i++) send_word(dir_tab[i]);
    n_sent = 0;
    while (n_sent < RAND_N) begin
      if (src_q.size() == 0) add_piece();
      r     = '0;
      r.b   = src_q.pop_front();
      r.fin = ($urandom_range(0, 39) == 0);
      send_word(r);
      n_sent++;
      if (n_sent % 64 == 0) calm_in = ($urandom_range(0, 3) == 0);
    end
    in_valid <= 1'b0;
    while (kept_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (n_err == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/cps_pkg.sv
hw/rtl/cps_step.sv
hw/rtl/c_comment_preproc_stripper.sv
dv/testbench.sv
